// ===== rtl/core/sqrot_pkg.sv =====
// sqrot_pkg: shared widths, types and helpers of the square image rotator
// depends on nothing; used by sqrot_ctrl and square_image_rotate_cw90
package sqrot_pkg;

  localparam int unsigned MAX_SIDE_N = 32;
  localparam int unsigned PIXEL_W    = 32;
  localparam int unsigned IDX_W      = $clog2(MAX_SIDE_N);
  localparam int unsigned ADDR_W     = 2 * IDX_W;
  localparam int unsigned DEPTH      = MAX_SIDE_N * MAX_SIDE_N;
  localparam int unsigned SIDE_W     = IDX_W + 1;

  localparam logic [SIDE_W-1:0] MAX_SIDE   = SIDE_W'(MAX_SIDE_N);
  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(32);

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef struct packed {
    logic               we;
    logic [ADDR_W-1:0]  waddr;
    logic [PIXEL_W-1:0] wdata;
    logic               re;
    logic [ADDR_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic not_ready;
  } res_t;

  function automatic logic [SIDE_W-1:0] side_clamp(input logic [SIDE_W-1:0] s);
    logic [SIDE_W-1:0] r;
    r = s;
    if (s == '0) begin
      r = SIDE_W'(1);
    end else if (s > MAX_SIDE) begin
      r = MAX_SIDE;
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/sqrot_ram.sv =====
// sqrot_ram: generic single-write, single-read ram with registered read data
// depends on nothing
module sqrot_ram #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sqrot_ctrl.sv =====
// sqrot_ctrl: load and fetch position counters, address mapping and result flags
// depends on sqrot_pkg
module sqrot_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            mode_i,
  input  logic [sqrot_pkg::PIXEL_W-1:0]   pixel_in_i,
  input  logic                            cfg_valid_i,
  input  logic [sqrot_pkg::SIDE_W-1:0]    cfg_side_length_i,
  output sqrot_pkg::mem_req_t             mem_o,
  output sqrot_pkg::res_t                 res_o
);

  logic [sqrot_pkg::SIDE_W-1:0] side_q, side;
  logic [sqrot_pkg::SIDE_W-1:0] side_m1;
  logic [sqrot_pkg::IDX_W-1:0]  lrow_q, lcol_q, frow_q, fcol_q;
  logic                         ready_q;
  sqrot_pkg::res_t              res_q;
  logic                         do_load, do_fetch;
  logic                         lcol_end, lrow_end, fcol_end, frow_end;

  function automatic logic lcol_end_f(input logic c, input logic r);
    return c && r;
  endfunction

  assign side    = sqrot_pkg::side_clamp(side_q);
  assign side_m1 = side - sqrot_pkg::SIDE_W'(1);

  assign do_load  = start_i && (mode_i == sqrot_pkg::MODE_LOAD);
  assign do_fetch = start_i && (mode_i == sqrot_pkg::MODE_FETCH);

  assign lcol_end = ({1'b0, lcol_q} == side_m1);
  assign lrow_end = ({1'b0, lrow_q} == side_m1);
  assign fcol_end = ({1'b0, fcol_q} == side_m1);
  assign frow_end = ({1'b0, frow_q} == side_m1);

  always_comb begin
    mem_o.we    = do_load && !cfg_valid_i;
    mem_o.waddr = {lrow_q, lcol_q};
    mem_o.wdata = pixel_in_i;
    mem_o.re    = do_fetch && ready_q && !cfg_valid_i;
    // output (r,c) reads input (side-1-c, r)
    mem_o.raddr = {side_m1[sqrot_pkg::IDX_W-1:0] - fcol_q, frow_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q  <= sqrot_pkg::SIDE_RESET;
      lrow_q  <= '0;
      lcol_q  <= '0;
      frow_q  <= '0;
      fcol_q  <= '0;
      ready_q <= 1'b0;
      res_q   <= '0;
    end else begin
      res_q <= '0;
      if (cfg_valid_i) begin
        side_q  <= cfg_side_length_i;
        lrow_q  <= '0;
        lcol_q  <= '0;
        frow_q  <= '0;
        fcol_q  <= '0;
        ready_q <= 1'b0;
      end else if (do_load) begin
        ready_q <= 1'b0;
        if (lcol_end) begin
          lcol_q <= '0;
          if (lrow_end) begin
            lrow_q  <= '0;
            ready_q <= 1'b1;
            frow_q  <= '0;
            fcol_q  <= '0;
          end else begin
            lrow_q <= lrow_q + sqrot_pkg::IDX_W'(1);
          end
        end else begin
          lcol_q <= lcol_q + sqrot_pkg::IDX_W'(1);
        end
      end else if (do_fetch) begin
        res_q.valid <= 1'b1;
        if (!ready_q) begin
          res_q.not_ready <= 1'b1;
        end else begin
          res_q.last <= lcol_end_f(fcol_end, frow_end);
          if (fcol_end) begin
            fcol_q <= '0;
            frow_q <= frow_end ? '0 : frow_q + sqrot_pkg::IDX_W'(1);
          end else begin
            fcol_q <= fcol_q + sqrot_pkg::IDX_W'(1);
          end
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

// ===== rtl/core/square_image_rotate_cw90.sv =====
// square_image_rotate_cw90: top level of the 90 degree clockwise image rotator
// depends on sqrot_pkg, sqrot_ctrl and sqrot_ram
//
// requests enter on start_i with mode_i: a load request stores pixel_in_i at the
// next row-major position and gives no result; a fetch request gives one result
// with valid_o high for exactly one cycle, the cycle right after the accepting
// edge (the ram read is registered at that edge). busy_o stays low, so one
// request is taken every cycle cfg_valid_i is low, loads and fetches mixed freely.
// completing a side x side square marks the image ready and rewinds the fetch
// position; fetches then walk the rotated image row-major, flag the final
// element with last_of_image_o and wrap. a fetch with no complete image gives
// not_ready_o high and zero data. the next load after a complete image starts
// a new one.
// side_length is written through cfg_valid_i/cfg_ready_o while idle; a write
// drops any partial image and rewinds both positions. 0 acts as 1, above 32 as 32.
// reset clears all positions, the ready flag and sets side to 32; the pixel
// store is not cleared. the receiver cannot stall results.
module square_image_rotate_cw90 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          mode_i,
  input  logic [sqrot_pkg::PIXEL_W-1:0] pixel_in_i,
  output logic                          valid_o,
  output logic [sqrot_pkg::PIXEL_W-1:0] pixel_out_o,
  output logic                          last_of_image_o,
  output logic                          not_ready_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sqrot_pkg::SIDE_W-1:0]  cfg_side_length_i
);

  sqrot_pkg::mem_req_t           mem_req;
  sqrot_pkg::res_t               res;
  logic [sqrot_pkg::PIXEL_W-1:0] rdata;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  sqrot_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .mode_i            (mode_i),
    .pixel_in_i        (pixel_in_i),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_side_length_i (cfg_side_length_i),
    .mem_o             (mem_req),
    .res_o             (res)
  );

  sqrot_ram #(
    .DATA_W (sqrot_pkg::PIXEL_W),
    .DEPTH  (sqrot_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (rdata)
  );

  assign valid_o         = res.valid;
  assign last_of_image_o = res.last;
  assign not_ready_o     = res.not_ready;
  assign pixel_out_o     = (res.valid && !res.not_ready) ? rdata : '0;

endmodule
